// File: rtl/core/dps_pkg.sv
// Package for the dynamic priority scheduler: slot count, item structs,
// slot status and controller state codes. No dependencies.
package dps_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = $clog2(SLOTS);
  // Internal slot index is at least as wide as the 3-bit slot_index field.
  localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;
  localparam int CNT_W  = SLOT_W;

  localparam logic signed [15:0] PRI_MIN = 16'sh8000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_READY = 2'd1,
    ST_DONE  = 2'd2
  } slot_status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctrl_state_t;

  typedef struct packed {
    logic               command;
    logic [2:0]         slot_index;
    logic [7:0]         task_id;
    logic signed [15:0] start_priority;
    logic [15:0]        run_time;
  } in_item_t;

  typedef struct packed {
    logic               was_load;
    logic               idle;
    logic [2:0]         served_slot;
    logic [7:0]         served_id;
    logic signed [15:0] new_priority;
    logic [15:0]        remaining;
    logic               finished;
  } out_item_t;

  // Slot write broadcast to every cell (load or post-tick update).
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   slot;
    logic [7:0]         id;
    logic signed [15:0] pri;
    logic [15:0]        rem;
  } slot_wr_t;

  // Best-so-far candidate passed down the cell row.
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         id;
    logic signed [15:0] pri;
    logic [15:0]        rem;
  } tok_t;

endpackage

// File: rtl/core/dps_cell.sv
// One task slot of the scheduler row: holds the slot and passes the
// best-so-far candidate to its neighbor each cycle. Uses dps_pkg.
module dps_cell import dps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  slot_wr_t         wr,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  slot_status_t       status_r;
  logic [7:0]         id_r;
  logic signed [15:0] pri_r;
  logic [15:0]        rem_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               hit;
  logic               take;

  assign hit = wr.en && (wr.slot == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_EMPTY;
    end else if (hit) begin
      status_r <= (wr.rem == 16'd0) ? ST_DONE : ST_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      id_r  <= wr.id;
      pri_r <= wr.pri;
      rem_r <= wr.rem;
    end
  end

  // Strictly greater: an earlier cell keeps the win on a tie.
  assign take = (status_r == ST_READY) &&
                (!tok_in.found || (pri_r > tok_in.pri));

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = cell_idx;
      tok_nxt.id    = id_r;
      tok_nxt.pri   = pri_r;
      tok_nxt.rem   = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: rtl/core/dynamic_priority_scheduler.sv
// Top level of the dynamic priority scheduler: command decode, scan control
// and result register over a row of dps_cell slots. Uses dps_pkg, dps_cell.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low.
//   A load writes one slot; its result strobes on out_valid the next cycle
//   and busy stays low, so loads may follow back to back.
//   A tick raises busy while the best candidate ripples down the row of
//   SLOTS cells, one cell per cycle; the served slot is then updated and
//   the result strobes in the cycle busy drops, after which the next item
//   can be taken. The length of the cell row sets how long the scan lasts.
//   Each result is on out_item for exactly one cycle with out_valid high;
//   the receiver cannot stall, so nothing is held back.
//   Reset (rst_n low, synchronous) marks every slot empty and clears
//   the controller and out_valid; slot contents are not cleared.
//   A tick that finds no ready slot returns idle with all other fields zero.
module dynamic_priority_scheduler import dps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  slot_wr_t         wr;
  tok_t             tok [0:SLOTS];
  tok_t             best;
  logic             accept;
  logic signed [15:0] pri_dec;
  logic [15:0]      rem_dec;

  assign tok[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    dps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .wr       (wr),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  assign best   = tok[SLOTS];
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign pri_dec = (best.pri == PRI_MIN) ? best.pri : best.pri - 16'sd1;
  assign rem_dec = (best.rem != 16'd0) ? best.rem - 16'd1 : best.rem;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.command == CMD_LOAD) begin
            wr.en  = 1'b1;
            wr.slot = IDX_W'(in_item.slot_index);
            wr.id  = in_item.task_id;
            wr.pri = in_item.start_priority;
            wr.rem = in_item.run_time;
            out_valid_nxt             = 1'b1;
            out_item_nxt.was_load     = 1'b1;
            out_item_nxt.idle         = 1'b0;
            out_item_nxt.served_slot  = in_item.slot_index;
            out_item_nxt.served_id    = in_item.task_id;
            out_item_nxt.new_priority = in_item.start_priority;
            out_item_nxt.remaining    = in_item.run_time;
            out_item_nxt.finished     = (in_item.run_time == 16'd0);
          end else begin
            state_nxt = S_SCAN;
            cnt_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        // Last cell output is settled once the candidate has crossed the row.
        if (cnt_r == CNT_W'(SLOTS - 1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          if (best.found) begin
            wr.en   = 1'b1;
            wr.slot = best.idx;
            wr.id   = best.id;
            wr.pri  = pri_dec;
            wr.rem  = rem_dec;
            out_item_nxt.served_slot  = best.idx[2:0];
            out_item_nxt.served_id    = best.id;
            out_item_nxt.new_priority = pri_dec;
            out_item_nxt.remaining    = rem_dec;
            out_item_nxt.finished     = (rem_dec == 16'd0);
          end else begin
            out_item_nxt.idle = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sim/testbench.sv
// Testbench for dynamic_priority_scheduler: directed and random load/tick items,
// checked against a slot-table scoreboard. Depends on dps_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import dps_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_TAIL   = 200;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 100;

  class slot_table_sb;
    slot_status_t       status [SLOTS];
    logic [7:0]         ids    [SLOTS];
    logic signed [15:0] pris   [SLOTS];
    logic [15:0]        rems   [SLOTS];
    out_item_t          due_results[$];
    int errors;
    int checked;
    int loads;
    int ticks;
    int idle_ticks;
    int floor_hits;

    function new();
      foreach (status[k]) status[k] = ST_EMPTY;
    endfunction

    // Advance the slot table by one accepted item and queue what it must return.
    function void note_command(in_item_t it);
      out_item_t e;
      int best;
      e = '0;
      best = -1;
      if (it.command == CMD_LOAD) begin
        loads++;
        if (it.slot_index < SLOTS) begin
          ids[it.slot_index]    = it.task_id;
          pris[it.slot_index]   = it.start_priority;
          rems[it.slot_index]   = it.run_time;
          status[it.slot_index] = (it.run_time == 0) ? ST_DONE : ST_READY;
        end
        e.was_load     = 1'b1;
        e.served_slot  = it.slot_index;
        e.served_id    = it.task_id;
        e.new_priority = it.start_priority;
        e.remaining    = it.run_time;
        e.finished     = (it.run_time == 0);
      end else begin
        ticks++;
        // strict compare keeps the lowest index on ties
        for (int k = 0; k < SLOTS; k++) begin
          if (status[k] == ST_READY && (best < 0 || pris[k] > pris[best])) best = k;
        end
        if (best < 0) begin
          idle_ticks++;
          e.idle = 1'b1;
        end else begin
          if (pris[best] == PRI_MIN) floor_hits++;
          else pris[best] = pris[best] - 16'sd1;
          if (rems[best] != 0) rems[best] = rems[best] - 16'd1;
          status[best]   = (rems[best] == 0) ? ST_DONE : ST_READY;
          e.served_slot  = 3'(best);
          e.served_id    = ids[best];
          e.new_priority = pris[best];
          e.remaining    = rems[best];
          e.finished     = (rems[best] == 0);
        end
      end
      due_results.push_back(e);
    endfunction

    function void field_ok(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("result with nothing outstanding: slot %0d id %0d",
                 got.served_slot, got.served_id);
        return;
      end
      e = due_results.pop_front();
      checked++;
      field_ok("was_load", e.was_load, got.was_load);
      field_ok("idle", e.idle, got.idle);
      field_ok("served_slot", e.served_slot, got.served_slot);
      field_ok("served_id", e.served_id, got.served_id);
      field_ok("new_priority", e.new_priority, got.new_priority);
      field_ok("remaining", e.remaining, got.remaining);
      field_ok("finished", e.finished, got.finished);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  slot_table_sb sb = new();
  int stall_cycles = 0;

  dynamic_priority_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor and watchdog: values read here are the ones before this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_command(in_item);
      if (out_valid) sb.check_result(out_item);
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Call at a rising edge; returns at the edge where the item was taken.
  task automatic drive_item(in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic in_item_t load_cmd(int slot, int id, int pri, int rt);
    in_item_t it;
    it.command        = CMD_LOAD;
    it.slot_index     = 3'(slot);
    it.task_id        = 8'(id);
    it.start_priority = 16'(pri);
    it.run_time       = 16'(rt);
    return it;
  endfunction

  function automatic in_item_t tick_cmd();
    in_item_t it;
    it = '0;
    it.command = CMD_TICK;
    return it;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    int r;
    it.command    = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_LOAD;
    it.slot_index = 3'($urandom_range(0, 7));
    it.task_id    = 8'($urandom);
    case ($urandom_range(0, 3))
      0:       it.start_priority = 16'($urandom);
      1:       it.start_priority = 16'($urandom_range(0, 6) - 3); // dense ties
      2:       it.start_priority = 16'sh7fff - 16'($urandom_range(0, 2));
      default: it.start_priority = PRI_MIN + 16'($urandom_range(0, 2));
    endcase
    r = $urandom_range(0, 9);
    if (r == 0)      it.run_time = 16'd0;
    else if (r <= 6) it.run_time = 16'($urandom_range(1, 4));
    else if (r <= 8) it.run_time = 16'($urandom_range(1, 300));
    else             it.run_time = 16'($urandom);
    return it;
  endfunction

  initial begin
    in_item_t directed[$];
    bit gaps_on;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(tick_cmd());                          // empty table
    directed.push_back(load_cmd(0, 8'hff, 32767, 65535));
    directed.push_back(load_cmd(2, 8'h5a, 32767, 2));
    directed.push_back(load_cmd(5, 8'ha5, 32767, 0));        // zero run time
    directed.push_back(load_cmd(7, 8'h00, -32768, 1));
    directed.push_back(load_cmd(3, 8'h3c, -32768, 3));
    directed.push_back(tick_cmd());                          // tie, slot 0 wins
    directed.push_back(tick_cmd());
    directed.push_back(tick_cmd());
    directed.push_back(load_cmd(0, 8'h11, 0, 0));            // overwrite occupied slot
    directed.push_back(tick_cmd());
    directed.push_back(tick_cmd());                          // floor, slot 3 over 7
    directed.push_back(tick_cmd());
    directed.push_back(tick_cmd());
    directed.push_back(tick_cmd());
    directed.push_back(tick_cmd());                          // everything finished
    directed.push_back(load_cmd(6, 8'h80, 1, 1));
    directed.push_back(load_cmd(1, 8'h7f, -1, 1));
    directed.push_back(tick_cmd());
    directed.push_back(tick_cmd());
    directed.push_back(tick_cmd());
    foreach (directed[k]) drive_item(directed[k]);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      drive_item(random_command());
      // every third block of 100 items runs back to back
      gaps_on = ((i / 100) % 3 != 0) && (i < RANDOM_ITEMS - QUIET_TAIL);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end

    drain();
    repeat (SLOTS + 4) @(posedge clk);
    $display("%0d loads and %0d ticks (%0d idle, %0d at the priority floor)",
             sb.loads, sb.ticks, sb.idle_ticks, sb.floor_hits);
    $display("%0d results compared, %0d field errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dps_pkg.sv
rtl/core/dps_cell.sv
rtl/core/dynamic_priority_scheduler.sv
sim/testbench.sv
